### src/nta_pkg.sv
package nta_pkg;

  localparam int TableDepthDefault = 16;
  localparam int MaxResults        = 16;

  localparam int AddrW   = 48;
  localparam int AgeW    = 8;
  localparam int WeightW = 8;
  localparam int SeqW    = 8;
  localparam int CmdW    = 2;
  localparam int KindW   = 2;

  localparam logic [AgeW-1:0] AgeReloadReset = 8'd3;

  localparam logic [CmdW-1:0] CMD_HELLO    = 2'd0;
  localparam logic [CmdW-1:0] CMD_REFRESH  = 2'd1;
  localparam logic [CmdW-1:0] CMD_ANNOUNCE = 2'd2;

  localparam logic [KindW-1:0] KIND_REFRESHED = 2'd0;
  localparam logic [KindW-1:0] KIND_ADDED     = 2'd1;
  localparam logic [KindW-1:0] KIND_FULL      = 2'd2;
  localparam logic [KindW-1:0] KIND_ANNOUNCE  = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0]   addr;
    logic [AgeW-1:0]    age;
    logic [WeightW-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [AddrW-1:0]   addr;
    logic [AgeW-1:0]    age;
    logic [WeightW-1:0] weight;
    logic [SeqW-1:0]    seq;
    logic               last;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

endpackage

### src/neighbor_table_with_aging_unit.sv
// One item at a time: hello, refresh and announce (with any valid entry) walk the table
// through the single read port of the slot memory; announce then passes a flush state.
// Announced entries leave at most one per cycle while the output is taken.
// Reset: valid bits cleared, sequence number zero, age_reload 3; no clearing pass.
module neighbor_table_with_aging_unit #(
  parameter int TableDepth = nta_pkg::TableDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [nta_pkg::AgeW-1:0]    cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nta_pkg::CmdW-1:0]    command,
  input  logic [nta_pkg::AddrW-1:0]   source_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nta_pkg::KindW-1:0]   kind,
  output logic [nta_pkg::AddrW-1:0]   entry_address,
  output logic [nta_pkg::AgeW-1:0]    remaining_age,
  output logic [nta_pkg::WeightW-1:0] entry_weight,
  output logic [nta_pkg::SeqW-1:0]    sequence_number,
  output logic                        last
);
  import nta_pkg::*;

  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  mem_ctrl_t       mem_ctrl;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;
  entry_t          rd_data;
  entry_t          wr_data;
  logic            out_free;
  logic            emit_valid;
  result_t         emit_res;

  nta_engine #(.Depth(TableDepth)) u_engine (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .source_address   (source_address),
    .out_free         (out_free),
    .emit_valid       (emit_valid),
    .emit_res         (emit_res),
    .mem_ctrl         (mem_ctrl),
    .rd_idx           (rd_idx),
    .rd_data          (rd_data),
    .wr_idx           (wr_idx),
    .wr_data          (wr_data)
  );

  nta_mem #(.Depth(TableDepth)) u_mem (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  nta_out u_out (
    .clk             (clk),
    .rst             (rst),
    .emit_valid      (emit_valid),
    .emit_res        (emit_res),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .entry_address   (entry_address),
    .remaining_age   (remaining_age),
    .entry_weight    (entry_weight),
    .sequence_number (sequence_number),
    .last            (last)
  );

endmodule

### src/nta_mem.sv
module nta_mem #(
  parameter int Depth = nta_pkg::TableDepthDefault,
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk,
  input  nta_pkg::mem_ctrl_t ctrl,
  input  logic [IdxW-1:0]   rd_idx,
  output nta_pkg::entry_t   rd_data,
  input  logic [IdxW-1:0]   wr_idx,
  input  nta_pkg::entry_t   wr_data
);
  import nta_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

### src/nta_out.sv
module nta_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        emit_valid,
  input  nta_pkg::result_t            emit_res,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nta_pkg::KindW-1:0]   kind,
  output logic [nta_pkg::AddrW-1:0]   entry_address,
  output logic [nta_pkg::AgeW-1:0]    remaining_age,
  output logic [nta_pkg::WeightW-1:0] entry_weight,
  output logic [nta_pkg::SeqW-1:0]    sequence_number,
  output logic                        last
);
  import nta_pkg::*;

  result_t res;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      res <= emit_res;
    end
  end

  assign kind            = res.kind;
  assign entry_address   = res.addr;
  assign remaining_age   = res.age;
  assign entry_weight    = res.weight;
  assign sequence_number = res.seq;
  assign last            = res.last;

endmodule

### src/nta_engine.sv
module nta_engine #(
  parameter int Depth = nta_pkg::TableDepthDefault,
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [nta_pkg::AgeW-1:0]   cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nta_pkg::CmdW-1:0]   command,
  input  logic [nta_pkg::AddrW-1:0]  source_address,
  input  logic                       out_free,
  output logic                       emit_valid,
  output nta_pkg::result_t           emit_res,
  output nta_pkg::mem_ctrl_t         mem_ctrl,
  output logic [IdxW-1:0]            rd_idx,
  input  nta_pkg::entry_t            rd_data,
  output logic [IdxW-1:0]            wr_idx,
  output nta_pkg::entry_t            wr_data
);
  import nta_pkg::*;

  localparam int CntW  = $clog2(Depth + 1);
  localparam int EmitW = $clog2(MaxResults + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  typedef enum logic [1:0] {IDLE, WALK, FLUSH} state_t;

  state_t             state;
  logic [CmdW-1:0]    cmd_q;
  logic [AddrW-1:0]   addr_q;
  logic [AgeW-1:0]    age_reload;
  logic [SeqW-1:0]    seq;
  logic [Depth-1:0]   slot_valid;
  logic [CntW-1:0]    cnt;
  logic               p_valid;
  logic [IdxW-1:0]    p_idx;
  logic               free_found;
  logic [IdxW-1:0]    free_idx;
  logic               pend_valid;
  result_t            pend;
  logic [EmitW-1:0]   n_emit;

  logic               s_valid;
  logic               at_end;
  logic               hit;
  logic               have_free;
  logic [IdxW-1:0]    free_pick;
  logic [AgeW-1:0]    age_dec;
  logic               keep;
  result_t            new_res;
  logic               wr_req;
  logic               set_req;
  logic               clr_req;
  logic               emit_req;
  logic               finish;
  logic               take;
  logic               stall;

  assign in_ready = (state == IDLE);
  assign rd_idx   = cnt[IdxW-1:0];

  always_comb begin
    s_valid   = slot_valid[p_idx];
    at_end    = p_valid && (p_idx == LastIdx);
    hit       = s_valid && (rd_data.addr == addr_q);
    have_free = free_found || !s_valid;
    free_pick = free_found ? free_idx : p_idx;
    age_dec   = rd_data.age - 1'b1;
    keep      = s_valid && (rd_data.age != '0) && (n_emit < EmitW'(MaxResults));
    new_res   = '{kind: KIND_ANNOUNCE, addr: rd_data.addr, age: age_dec,
                  weight: rd_data.weight, seq: seq, last: 1'b0};

    wr_req   = 1'b0;
    wr_idx   = p_idx;
    wr_data  = rd_data;
    set_req  = 1'b0;
    clr_req  = 1'b0;
    emit_req = 1'b0;
    emit_res = pend;
    finish   = 1'b0;
    take     = 1'b0;

    if (state == WALK && p_valid) begin
      case (cmd_q)
        CMD_HELLO: begin
          if (hit) begin
            wr_req         = 1'b1;
            wr_data.age    = age_reload;
            emit_req       = 1'b1;
            emit_res       = '{kind: KIND_REFRESHED, addr: addr_q, age: age_reload,
                               weight: rd_data.weight, seq: seq, last: 1'b1};
            finish         = 1'b1;
          end else if (at_end) begin
            finish   = 1'b1;
            emit_req = 1'b1;
            if (have_free) begin
              wr_req   = 1'b1;
              wr_idx   = free_pick;
              wr_data  = '{addr: addr_q, age: age_reload, weight: WeightW'(1)};
              set_req  = 1'b1;
              emit_res = '{kind: KIND_ADDED, addr: addr_q, age: age_reload,
                           weight: WeightW'(1), seq: seq, last: 1'b1};
            end else begin
              emit_res = '{kind: KIND_FULL, addr: addr_q, age: '0,
                           weight: '0, seq: seq, last: 1'b1};
            end
          end
        end
        CMD_REFRESH: begin
          if (s_valid) begin
            if (rd_data.age == '0) begin
              clr_req = 1'b1;
            end else begin
              wr_req         = 1'b1;
              wr_data.age    = age_dec;
              wr_data.weight = WeightW'(1);
            end
          end
          finish = at_end;
        end
        CMD_ANNOUNCE: begin
          if (s_valid) begin
            if (rd_data.age == '0) begin
              clr_req = 1'b1;
            end else begin
              wr_req      = 1'b1;
              wr_data.age = age_dec;
            end
          end
          // previous kept entry goes out once a later one proves it is not last
          take     = keep;
          emit_req = keep && pend_valid;
          finish   = at_end;
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end

    if (state == FLUSH) begin
      emit_req      = pend_valid;
      emit_res      = pend;
      emit_res.last = 1'b1;
    end

    stall          = emit_req && !out_free;
    emit_valid     = emit_req && out_free;
    mem_ctrl.wr_en = wr_req && !stall;
    mem_ctrl.rd_en = (state == WALK) && !stall && !finish && (cnt < CntW'(Depth));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      age_reload <= AgeReloadReset;
      seq        <= '0;
      slot_valid <= '0;
      cnt        <= '0;
      p_valid    <= 1'b0;
      free_found <= 1'b0;
      pend_valid <= 1'b0;
      n_emit     <= '0;
    end else begin
      if (cfg_write_enable) begin
        age_reload <= cfg_write_data;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cmd_q      <= command;
            addr_q     <= source_address;
            cnt        <= '0;
            p_valid    <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            n_emit     <= '0;
            if (command == CMD_HELLO || command == CMD_REFRESH) begin
              state <= WALK;
            end else if (command == CMD_ANNOUNCE && (|slot_valid)) begin
              state <= WALK;
              seq   <= seq + 1'b1;
            end
          end
        end
        WALK: begin
          if (!stall) begin
            if (mem_ctrl.rd_en) begin
              cnt <= cnt + 1'b1;
            end
            p_valid <= mem_ctrl.rd_en;
            p_idx   <= rd_idx;
            if (clr_req) begin
              slot_valid[p_idx] <= 1'b0;
            end
            if (set_req) begin
              slot_valid[free_pick] <= 1'b1;
            end
            if (cmd_q == CMD_HELLO && p_valid && !s_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= p_idx;
            end
            if (take) begin
              pend       <= new_res;
              pend_valid <= 1'b1;
              n_emit     <= n_emit + 1'b1;
            end
            if (finish) begin
              state <= (cmd_q == CMD_ANNOUNCE) ? FLUSH : IDLE;
            end
          end
        end
        FLUSH: begin
          if (!stall) begin
            pend_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### tb/neighbor_table_checker.sv
module neighbor_table_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [nta_pkg::AgeW-1:0]    cfg_write_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [nta_pkg::CmdW-1:0]    command,
  input  logic [nta_pkg::AddrW-1:0]   source_address,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [nta_pkg::KindW-1:0]   kind,
  input  logic [nta_pkg::AddrW-1:0]   entry_address,
  input  logic [nta_pkg::AgeW-1:0]    remaining_age,
  input  logic [nta_pkg::WeightW-1:0] entry_weight,
  input  logic [nta_pkg::SeqW-1:0]    sequence_number,
  input  logic                        last,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import nta_pkg::*;

  localparam int Depth = TableDepthDefault;

  logic               slot_used   [Depth];
  logic [AddrW-1:0]   slot_mac    [Depth];
  logic [AgeW-1:0]    slot_age    [Depth];
  logic [WeightW-1:0] slot_weight [Depth];
  logic [SeqW-1:0]    announce_seq;
  logic [AgeW-1:0]    reload_age;
  result_t            pending_reports [$];
  int                 error_total;

  task automatic push_report(input logic [KindW-1:0] k, input logic [AddrW-1:0] mac,
                             input logic [AgeW-1:0] age, input logic [WeightW-1:0] weight,
                             input logic fin);
    result_t r;
    r.kind   = k;
    r.addr   = mac;
    r.age    = age;
    r.weight = weight;
    r.seq    = announce_seq;
    r.last   = fin;
    pending_reports.push_back(r);
  endtask

  task automatic age_entries(input logic reset_weight);
    for (int i = 0; i < Depth; i++) begin
      if (slot_used[i]) begin
        if (slot_age[i] == '0) begin
          slot_used[i] = 1'b0;
        end else begin
          slot_age[i] = slot_age[i] - 1'b1;
          if (reset_weight) slot_weight[i] = 8'd1;
        end
      end
    end
  endtask

  task automatic apply_command(input logic [CmdW-1:0] cmd, input logic [AddrW-1:0] mac);
    int hit;
    int free_slot;
    int remaining;
    int emitted;
    hit       = -1;
    free_slot = -1;
    remaining = 0;
    emitted   = 0;
    case (cmd)
      CMD_HELLO: begin
        for (int i = 0; i < Depth; i++) begin
          if (slot_used[i]) begin
            if (hit < 0 && slot_mac[i] == mac) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          slot_age[hit] = reload_age;
          push_report(KIND_REFRESHED, mac, reload_age, slot_weight[hit], 1'b1);
        end else if (free_slot < 0) begin
          push_report(KIND_FULL, mac, '0, '0, 1'b1);
        end else begin
          slot_used[free_slot]   = 1'b1;
          slot_mac[free_slot]    = mac;
          slot_age[free_slot]    = reload_age;
          slot_weight[free_slot] = 8'd1;
          push_report(KIND_ADDED, mac, reload_age, 8'd1, 1'b1);
        end
      end
      CMD_REFRESH: age_entries(1'b1);
      CMD_ANNOUNCE: begin
        for (int i = 0; i < Depth; i++) if (slot_used[i]) remaining++;
        if (remaining != 0) begin
          announce_seq = announce_seq + 1'b1;
          age_entries(1'b0);
          remaining = 0;
          for (int i = 0; i < Depth; i++) if (slot_used[i]) remaining++;
          if (remaining > MaxResults) remaining = MaxResults;
          for (int i = 0; i < Depth; i++) begin
            if (slot_used[i] && emitted < remaining) begin
              push_report(KIND_ANNOUNCE, slot_mac[i], slot_age[i], slot_weight[i],
                          emitted == remaining - 1);
              emitted++;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
      announce_seq = '0;
      reload_age   = AgeReloadReset;
      pending_reports.delete();
    end else begin
      if (cfg_write_enable) reload_age = cfg_write_data;
      if (out_valid && out_ready) begin
        got.kind   = kind;
        got.addr   = entry_address;
        got.age    = remaining_age;
        got.weight = entry_weight;
        got.seq    = sequence_number;
        got.last   = last;
        if (pending_reports.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("unexpected result: kind=%0d addr=%h age=%0d weight=%0d seq=%0d last=%0d",
                     got.kind, got.addr, got.age, got.weight, got.seq, got.last);
        end else begin
          want = pending_reports.pop_front();
          if (got.kind !== want.kind || got.addr !== want.addr || got.age !== want.age ||
              got.weight !== want.weight || got.seq !== want.seq || got.last !== want.last)
          begin
            error_total++;
            if (error_total <= 10) begin
              $display("mismatch: expected kind=%0d addr=%h age=%0d weight=%0d seq=%0d last=%0d",
                       want.kind, want.addr, want.age, want.weight, want.seq, want.last);
              $display("          got      kind=%0d addr=%h age=%0d weight=%0d seq=%0d last=%0d",
                       got.kind, got.addr, got.age, got.weight, got.seq, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) apply_command(command, source_address);
    end
    mismatches  <= error_total;
    outstanding <= pending_reports.size();
  end

endmodule

### tb/neighbor_table_with_aging_unit_test.sv
module neighbor_table_with_aging_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nta_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int PoolSize     = 24;
  localparam int PhaseItems   = 33;
  localparam int TailCycles   = 2 * TableDepthDefault + 8;
  localparam int CycleLimit   = 400000;

  logic                 clk              = 1'b0;
  logic                 rst              = 1'b1;
  logic                 cfg_write_enable = 1'b0;
  logic [AgeW-1:0]      cfg_write_data   = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [CmdW-1:0]      command          = '0;
  logic [AddrW-1:0]     source_address   = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [KindW-1:0]     kind;
  logic [AddrW-1:0]     entry_address;
  logic [AgeW-1:0]      remaining_age;
  logic [WeightW-1:0]   entry_weight;
  logic [SeqW-1:0]      sequence_number;
  logic                 last;

  int                   mismatch_count;
  int                   outstanding;
  int                   cycle_count;
  int                   burst_left;
  int                   ready_mode;
  int                   mode_left;
  int                   stall_left;
  logic [AddrW-1:0]     mac_pool [PoolSize];
  logic [AgeW-1:0]      reload_plan [4];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  neighbor_table_with_aging_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .source_address   (source_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .entry_address    (entry_address),
    .remaining_age    (remaining_age),
    .entry_weight     (entry_weight),
    .sequence_number  (sequence_number),
    .last             (last)
  );

  neighbor_table_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .source_address   (source_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .entry_address    (entry_address),
    .remaining_age    (remaining_age),
    .entry_weight     (entry_weight),
    .sequence_number  (sequence_number),
    .last             (last),
    .mismatches       (mismatch_count),
    .outstanding      (outstanding)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("neighbor_table_with_aging_unit test failed");
    $finish;
  end

  // receiver: modes of always ready, coin flip, occasional long stall, mostly ready
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(30, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 20);
        end
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [AddrW-1:0] mac);
    int gap;
    in_valid       <= 1'b1;
    command        <= cmd;
    source_address <= mac;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap        = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // refresh ticks and empty announces leave nothing to wait on, hence the tail
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_reload(input logic [AgeW-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0]      wide;
    logic [CmdW-1:0]  cmd;
    logic [AddrW-1:0] mac;
    int               pick;
    int               sent;

    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      wide        = {$urandom, $urandom};
      mac_pool[i] = wide[AddrW-1:0];
    end
    reload_plan[0] = 8'd0;
    reload_plan[1] = 8'd255;
    reload_plan[2] = 8'd1;
    reload_plan[3] = AgeW'($urandom_range(2, 8));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_ANNOUNCE, '0);
    send_item(CMD_HELLO, mac_pool[0]);
    send_item(CMD_HELLO, mac_pool[1]);
    send_item(CMD_HELLO, mac_pool[0]);
    send_item(CMD_REFRESH, mac_pool[1]);
    send_item(CMD_ANNOUNCE, mac_pool[1]);
    for (int i = 2; i < 16; i++) send_item(CMD_HELLO, mac_pool[i]);
    send_item(CMD_HELLO, mac_pool[16]);
    send_item(CMD_HELLO, mac_pool[5]);
    send_item(CMD_ANNOUNCE, '0);
    send_item(CmdUnused, '1);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_reload(reload_plan[phase]);
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 85) mac = mac_pool[$urandom_range(0, PoolSize - 1)];
        else mac = wide[AddrW-1:0];
        if (pick < 60) cmd = CMD_HELLO;
        else if (pick < 75) cmd = CMD_REFRESH;
        else if (pick < 95) cmd = CMD_ANNOUNCE;
        else cmd = CmdUnused;
        if (cmd != CmdUnused) sent++;
        send_item(cmd, mac);
      end
    end

    drain();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("neighbor_table_with_aging_unit test passed");
    end else begin
      $display("neighbor_table_with_aging_unit test failed");
    end
    $finish;
  end

endmodule
